### design/rcbc_pkg.sv
package rcbc_pkg;

  // reference store geometry (REF_LEN is a power of two)
  localparam int REF_LEN    = 65536;
  localparam int ADDR_W     = $clog2(REF_LEN);
  localparam int LEN_W      = ADDR_W + 1;
  localparam int MAX_READ   = 1024;

  // fixed field widths
  localparam int CMD_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int MATE_W     = 2;
  localparam int STRAND_W   = 2;
  localparam int OFFSET_W   = 16;
  localparam int LOC_W      = 17;
  localparam int READ_LEN_W = 11;
  localparam int CAT_W      = 4;
  localparam int COUNT_W    = 17;
  localparam int CODE_W     = 3;

  // one-based position: offset + location + read index
  localparam int POS_W      = LOC_W + 1;
  localparam int CMP_W      = (POS_W > LEN_W) ? POS_W : LEN_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RECORD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REPORT = 2'd2;

  // mate and strand codes
  localparam logic [MATE_W-1:0]   MATE_1    = 2'd1;
  localparam logic [MATE_W-1:0]   MATE_2    = 2'd2;
  localparam logic [STRAND_W-1:0] STRAND_WW = 2'd0;
  localparam logic [STRAND_W-1:0] STRAND_CW = 2'd1;
  localparam logic [STRAND_W-1:0] STRAND_WC = 2'd2;
  localparam logic [STRAND_W-1:0] STRAND_CC = 2'd3;

  // reference characters
  localparam logic [CHAR_W-1:0] CH_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_T = 8'h54;
  localparam logic [CHAR_W-1:0] CH_G = 8'h47;
  localparam logic [CHAR_W-1:0] CH_C = 8'h43;
  localparam logic [CHAR_W-1:0] CH_N = 8'h4E;

  // stored base codes
  localparam logic [CODE_W-1:0] BASE_NONE = 3'd0;
  localparam logic [CODE_W-1:0] BASE_A    = 3'd1;
  localparam logic [CODE_W-1:0] BASE_T    = 3'd2;
  localparam logic [CODE_W-1:0] BASE_G    = 3'd3;
  localparam logic [CODE_W-1:0] BASE_C    = 3'd4;
  localparam logic [CODE_W-1:0] BASE_N    = 3'd5;

  // report categories
  localparam int NUM_BASES = 5;
  localparam int NUM_CAT   = 2 * NUM_BASES;
  localparam logic [CAT_W-1:0] CAT_COV_A   = 4'd0;
  localparam logic [CAT_W-1:0] CAT_TOT_COV = 4'd10;
  localparam logic [CAT_W-1:0] CAT_TOT_UNC = 4'd11;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [CHAR_W-1:0]     base_char;
    logic                  unique_map;
    logic [MATE_W-1:0]     mate_number;
    logic [STRAND_W-1:0]   strand_code;
    logic                  ref_found;
    logic [OFFSET_W-1:0]   ref_offset;
    logic [LOC_W-1:0]      location;
    logic [READ_LEN_W-1:0] read_length;
  } in_item_t;

  typedef struct packed {
    logic [CAT_W-1:0]   category;
    logic [COUNT_W-1:0] count;
    logic               last;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_MARK,
    OP_REPORT
  } op_kind_t;

  typedef struct packed {
    op_kind_t              kind;
    logic [CODE_W-1:0]     code;
    logic [POS_W-1:0]      start;
    logic [READ_LEN_W-1:0] len;
  } op_t;

  function automatic logic [CODE_W-1:0] encode_base(input logic [CHAR_W-1:0] ch);
    logic [CODE_W-1:0] code;
    case (ch)
      CH_A:    code = BASE_A;
      CH_T:    code = BASE_T;
      CH_G:    code = BASE_G;
      CH_C:    code = BASE_C;
      CH_N:    code = BASE_N;
      default: code = BASE_NONE;
    endcase
    return code;
  endfunction

endpackage

### design/rcbc_front.sv
module rcbc_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  rcbc_pkg::in_item_t in_item,
  input  logic               q_full,
  output logic               push,
  output rcbc_pkg::op_t      push_op
);
  import rcbc_pkg::*;

  logic                  counted;
  logic                  keep;
  logic [READ_LEN_W-1:0] len_sat;

  assign in_ready = !q_full;

  // record filter: unique, reference known, mate and strand agree
  assign counted = in_item.unique_map && in_item.ref_found &&
                   ((in_item.mate_number == MATE_1 &&
                     (in_item.strand_code == STRAND_WW || in_item.strand_code == STRAND_CW)) ||
                    (in_item.mate_number == MATE_2 &&
                     (in_item.strand_code == STRAND_WC || in_item.strand_code == STRAND_CC)));

  // clamp read length
  assign len_sat = (in_item.read_length > READ_LEN_W'(MAX_READ)) ?
                   READ_LEN_W'(MAX_READ) : in_item.read_length;

  // classify the item into a back-end operation
  always_comb begin
    push_op.code  = encode_base(in_item.base_char);
    push_op.start = POS_W'(in_item.ref_offset) + POS_W'(in_item.location);
    push_op.len   = len_sat;
    push_op.kind  = OP_LOAD;
    keep          = 1'b0;
    case (in_item.cmd)
      CMD_LOAD: begin
        push_op.kind = OP_LOAD;
        keep         = 1'b1;
      end
      CMD_RECORD: begin
        push_op.kind = OP_MARK;
        keep         = counted;
      end
      CMD_REPORT: begin
        push_op.kind = OP_REPORT;
        keep         = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = in_valid && in_ready && keep;

endmodule

### design/rcbc_queue.sv
module rcbc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rcbc_pkg::op_t push_op,
  input  logic          pop,
  output rcbc_pkg::op_t head,
  output logic          q_full,
  output logic          q_empty
);
  import rcbc_pkg::*;

  op_t               entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] fill_r;
  logic              do_push;
  logic              do_pop;

  assign q_full  = (fill_r == QCNT_W'(QUEUE_DEPTH));
  assign q_empty = (fill_r == '0);
  assign head    = entry_r[rd_ptr_r];
  assign do_push = push && !q_full;
  assign do_pop  = pop && !q_empty;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

### design/rcbc_back.sv
module rcbc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  rcbc_pkg::op_t       head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output rcbc_pkg::out_item_t out_item
);
  import rcbc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MARK = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t                state_r;
  state_t                state_nxt;
  logic [LEN_W-1:0]      loaded_len_r;
  logic [POS_W-1:0]      pos1_r;
  logic [READ_LEN_W-1:0] rem_r;
  logic [LEN_W-1:0]      scan_addr_r;
  logic                  rd_vld_r;
  logic [CAT_W-1:0]      emit_k_r;
  logic                  out_valid_r;
  out_item_t             out_item_r;

  logic [CODE_W-1:0]     base_mem [REF_LEN];
  logic                  mark_mem [REF_LEN];
  logic [CODE_W-1:0]     base_rd_r;
  logic                  mark_rd_r;

  logic [COUNT_W-1:0]    cnt_r [NUM_CAT];
  logic [COUNT_W-1:0]    tot_cov_r;
  logic [COUNT_W-1:0]    tot_unc_r;

  logic                  store_full;
  logic                  base_we;
  logic                  mark_set;
  logic                  mark_we;
  logic [ADDR_W-1:0]     mark_wa;
  logic [POS_W-1:0]      pos0;
  logic                  pos_in_range;
  logic                  rd_issue;
  logic                  scan_start;
  logic                  code_ok;
  logic [CAT_W-1:0]      hit_idx;
  logic                  out_free;
  logic                  emit_go;
  logic [COUNT_W-1:0]    emit_count;

  assign store_full = (loaded_len_r == LEN_W'(REF_LEN));
  assign pop        = (state_r == ST_IDLE) && !q_empty;
  assign base_we    = pop && (head.kind == OP_LOAD) && !store_full;
  assign scan_start = pop && (head.kind == OP_REPORT);

  // marking: position must be at least one and land below the loaded length
  assign pos0         = pos1_r - 1'b1;
  assign pos_in_range = (pos1_r != '0) && (CMP_W'(pos0) < CMP_W'(loaded_len_r));
  assign mark_set     = (state_r == ST_MARK) && (rem_r != '0) && pos_in_range;

  // a load clears its mark, so marks never need a clearing pass
  assign mark_we = base_we || mark_set;
  assign mark_wa = base_we ? loaded_len_r[ADDR_W-1:0] : pos0[ADDR_W-1:0];

  assign rd_issue = (state_r == ST_SCAN) && (scan_addr_r < loaded_len_r);

  // category of the base read back during a scan
  assign code_ok = (base_rd_r >= BASE_A) && (base_rd_r <= BASE_N);
  assign hit_idx = CAT_W'(base_rd_r - BASE_A) + (mark_rd_r ? '0 : CAT_W'(NUM_BASES));

  assign out_free = !out_valid_r || out_ready;
  assign emit_go  = (state_r == ST_EMIT) && out_free;

  // count selected for the next result
  always_comb begin
    if (emit_k_r == CAT_TOT_COV) begin
      emit_count = tot_cov_r;
    end else if (emit_k_r == CAT_TOT_UNC) begin
      emit_count = tot_unc_r;
    end else if (emit_k_r < CAT_W'(NUM_CAT)) begin
      emit_count = cnt_r[emit_k_r];
    end else begin
      emit_count = '0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (pop && head.kind == OP_MARK) begin
          state_nxt = ST_MARK;
        end else if (scan_start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_MARK: begin
        if (rem_r == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!rd_issue && !rd_vld_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go && emit_k_r == CAT_TOT_UNC) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // base and mark stores with registered reads
  always_ff @(posedge clk) begin
    if (base_we) begin
      base_mem[loaded_len_r[ADDR_W-1:0]] <= head.code;
    end
    base_rd_r <= base_mem[scan_addr_r[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_wa] <= !base_we;
    end
    mark_rd_r <= mark_mem[scan_addr_r[ADDR_W-1:0]];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      loaded_len_r <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (base_we) begin
        loaded_len_r <= loaded_len_r + 1'b1;
      end
      rd_vld_r <= rd_issue;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // mark walk, scan address and result index
  always_ff @(posedge clk) begin
    if (pop) begin
      pos1_r <= head.start;
      rem_r  <= head.len;
    end else if (state_r == ST_MARK && rem_r != '0) begin
      pos1_r <= pos1_r + 1'b1;
      rem_r  <= rem_r - 1'b1;
    end
    if (scan_start) begin
      scan_addr_r <= '0;
    end else if (rd_issue) begin
      scan_addr_r <= scan_addr_r + 1'b1;
    end
    if (state_r == ST_SCAN) begin
      emit_k_r <= CAT_COV_A;
    end else if (emit_go) begin
      emit_k_r <= emit_k_r + 1'b1;
    end
  end

  // one counter per category, plus the two totals
  for (genvar c = 0; c < NUM_CAT; c++) begin : g_cnt
    always_ff @(posedge clk) begin
      if (scan_start) begin
        cnt_r[c] <= '0;
      end else if (rd_vld_r && code_ok && hit_idx == CAT_W'(c) && cnt_r[c] != COUNT_MAX) begin
        cnt_r[c] <= cnt_r[c] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      tot_cov_r <= '0;
      tot_unc_r <= '0;
    end else if (rd_vld_r && code_ok) begin
      if (mark_rd_r && tot_cov_r != COUNT_MAX) begin
        tot_cov_r <= tot_cov_r + 1'b1;
      end
      if (!mark_rd_r && tot_unc_r != COUNT_MAX) begin
        tot_unc_r <= tot_unc_r + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_item_r.category <= emit_k_r;
      out_item_r.count    <= emit_count;
      out_item_r.last     <= (emit_k_r == CAT_TOT_UNC);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### design/read_coverage_base_composition.sv
// Coverage base composition of a loaded reference.
// Input channel (in_valid/in_ready/in_item) takes three kinds of item: a load
// appends one reference base, a record marks the positions it aligns to as
// covered, a report scans the reference. Only a report gives results: twelve
// items on out_valid/out_ready/out_item, covered A,T,G,C,N, uncovered
// A,T,G,C,N, covered total, uncovered total, with last set on the final one.
// Items pass through a two-entry queue to a back end that runs one at a time;
// each leaves the queue once the back end is idle, then:
//   load    nothing more
//   record  one read position per cycle (read_length clamped at 1024), each
//           written on the mark port if it lands in the loaded range
//   report  a scan with one read per cycle on the base and mark stores over
//           the loaded length, then the 12 results, held while out_ready is low
// Filtered records and unused commands never enter the queue.
// Reset empties the queue, sets the loaded length to zero and drops any pending
// result; no clearing pass is needed, since each load clears its own mark.
// A stalled receiver holds the back end only while a report is emitting; the
// output register lets the next item start while the last result waits, and the
// queue keeps accepting until it is full.
module read_coverage_base_composition (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rcbc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output rcbc_pkg::out_item_t out_item
);
  import rcbc_pkg::*;

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  op_t  push_op;
  op_t  head;

  // classify incoming items
  rcbc_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .push     (push),
    .push_op  (push_op)
  );

  // decoupling queue
  rcbc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  // execute operations
  rcbc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // the final result of a report is the uncovered total
  a_last_is_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |-> out_item.category == CAT_TOT_UNC)
    else $error("last result is not the uncovered total");

  // a report begins with the covered A count
  a_report_starts: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_item.category == CAT_COV_A)
    else $error("report did not start at the first category");

  // results of one report follow without a gap
  a_report_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_item.last |=> out_valid)
    else $error("gap inside a report");

  // the back end never takes from an empty queue
  a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule

### tb/sv/read_coverage_base_composition_check.sv
module read_coverage_base_composition_check (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  rcbc_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  rcbc_pkg::out_item_t out_item,
  output int                  errors,
  output int                  pending
);

  timeunit 1ns;
  timeprecision 1ps;

  import rcbc_pkg::*;

  // local copy of the reference, its coverage and the loaded length
  logic [CODE_W-1:0] base_codes [REF_LEN];
  logic              covered    [REF_LEN];
  int                ref_fill;

  // composition counts still to come out, oldest first
  out_item_t composition_due [$];

  // character to stored base code
  function automatic logic [CODE_W-1:0] base_code(input logic [CHAR_W-1:0] ch);
    case (ch)
      CH_A:    return BASE_A;
      CH_T:    return BASE_T;
      CH_G:    return BASE_G;
      CH_C:    return BASE_C;
      CH_N:    return BASE_N;
      default: return BASE_NONE;
    endcase
  endfunction

  // saturating count add
  function automatic int count_add(input int a, input int b);
    int s;
    s = a + b;
    return (s > int'(COUNT_MAX)) ? int'(COUNT_MAX) : s;
  endfunction

  // a record that passes the mapping filter marks its aligned span
  task automatic mark_alignment(input in_item_t it);
    logic counted;
    int   span;
    int   pos1;
    counted = it.unique_map && it.ref_found &&
              ((it.mate_number == MATE_1 &&
                (it.strand_code == STRAND_WW || it.strand_code == STRAND_CW)) ||
               (it.mate_number == MATE_2 &&
                (it.strand_code == STRAND_WC || it.strand_code == STRAND_CC)));
    if (counted) begin
      span = (int'(it.read_length) > MAX_READ) ? MAX_READ : int'(it.read_length);
      for (int i = 0; i < span; i++) begin
        pos1 = int'(it.ref_offset) + int'(it.location) + i;
        // one-based position, clipped below one and at the loaded length
        if (pos1 >= 1 && pos1 - 1 < ref_fill)
          covered[pos1 - 1] = 1'b1;
      end
    end
  endtask

  // scan the loaded reference and queue the twelve counts
  task automatic predict_composition();
    int        tally [NUM_CAT];
    int        cov_total;
    int        unc_total;
    int        idx;
    out_item_t res;
    cov_total = 0;
    unc_total = 0;
    foreach (tally[k]) tally[k] = 0;
    for (int i = 0; i < ref_fill; i++) begin
      if (base_codes[i] >= BASE_A && base_codes[i] <= BASE_N) begin
        idx = int'(base_codes[i]) - int'(BASE_A) + (covered[i] ? 0 : NUM_BASES);
        tally[idx] = count_add(tally[idx], 1);
      end
    end
    for (int k = 0; k < NUM_BASES; k++) begin
      cov_total = count_add(cov_total, tally[k]);
      unc_total = count_add(unc_total, tally[k + NUM_BASES]);
    end
    for (int k = 0; k < NUM_CAT + 2; k++) begin
      res.category = CAT_COV_A + CAT_W'(k);
      if (k < NUM_CAT)
        res.count = COUNT_W'(tally[k]);
      else if (res.category == CAT_TOT_COV)
        res.count = COUNT_W'(cov_total);
      else
        res.count = COUNT_W'(unc_total);
      res.last = (res.category == CAT_TOT_UNC);
      composition_due.push_back(res);
    end
  endtask

  // predict on accepted inputs, compare accepted outputs
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      ref_fill = 0;
      foreach (covered[i]) begin
        covered[i]    = 1'b0;
        base_codes[i] = BASE_NONE;
      end
      composition_due.delete();
      errors = 0;
    end else begin
      if (in_valid && in_ready) begin
        case (in_item.cmd)
          CMD_LOAD: begin
            if (ref_fill < REF_LEN) begin
              base_codes[ref_fill] = base_code(in_item.base_char);
              ref_fill++;
            end
          end
          CMD_RECORD: mark_alignment(in_item);
          CMD_REPORT: predict_composition();
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (composition_due.size() == 0) begin
          errors = errors + 1;
          $display("%0t: unexpected item cat=%0d count=%0d last=%0b", $time,
                   out_item.category, out_item.count, out_item.last);
        end else begin
          want = composition_due.pop_front();
          if (out_item.category !== want.category || out_item.count !== want.count ||
              out_item.last !== want.last) begin
            errors = errors + 1;
            $display("%0t: mismatch expected cat=%0d count=%0d last=%0b, %s",
                     $time, want.category, want.count, want.last,
                     $sformatf("got cat=%0d count=%0d last=%0b",
                               out_item.category, out_item.count, out_item.last));
          end
        end
      end
    end
    pending <= composition_due.size();
  end

endmodule

### tb/sv/read_coverage_base_composition_test.sv
module read_coverage_base_composition_test;

  timeunit 1ns;
  timeprecision 1ps;

  import rcbc_pkg::*;

  // codes the package leaves unnamed
  localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
  localparam logic [MATE_W-1:0] MATE_OTHER = 2'd0;
  localparam logic [MATE_W-1:0] MATE_BAD   = 2'd3;

  // cycles without any handshake before the run is declared hung
  localparam int HANG_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 2200;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic      no_idle = 1'b0;
  int        errors;
  int        pending;
  int        loads_sent;
  int        quiet_cycles;

  read_coverage_base_composition i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  read_coverage_base_composition_check i_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .errors   (errors),
    .pending  (pending)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // receiver stalls at random
  always @(negedge clk) begin
    out_ready = rst_n && (no_idle || $urandom_range(99) >= 14);
  end

  // hang detection
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // item with every field random
  function automatic in_item_t random_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return in_item_t'(r[$bits(in_item_t)-1:0]);
  endfunction

  // mostly valid bases, sometimes any byte
  function automatic logic [CHAR_W-1:0] pick_base();
    case ($urandom_range(9))
      0, 1:    return CH_A;
      2, 3:    return CH_T;
      4, 5:    return CH_G;
      6, 7:    return CH_C;
      8:       return CH_N;
      default: return CHAR_W'($urandom_range(255));
    endcase
  endfunction

  // drive one item, called and returning at a falling edge
  task automatic send(input in_item_t it);
    while (!no_idle && $urandom_range(99) < 14) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (it.cmd == CMD_LOAD)
      loads_sent++;
  endtask

  task automatic load_base(input logic [CHAR_W-1:0] ch);
    in_item_t it;
    it = random_item();
    it.cmd = CMD_LOAD;
    it.base_char = ch;
    send(it);
  endtask

  task automatic send_record(input logic [OFFSET_W-1:0] off, input logic [LOC_W-1:0] loc,
                             input logic [READ_LEN_W-1:0] len, input logic [MATE_W-1:0] mate,
                             input logic [STRAND_W-1:0] strand, input logic uniq,
                             input logic found);
    in_item_t it;
    it = random_item();
    it.cmd = CMD_RECORD;
    it.ref_offset = off;
    it.location = loc;
    it.read_length = len;
    it.mate_number = mate;
    it.strand_code = strand;
    it.unique_map = uniq;
    it.ref_found = found;
    send(it);
  endtask

  task automatic send_report();
    in_item_t it;
    it = random_item();
    it.cmd = CMD_REPORT;
    send(it);
  endtask

  // counted record landing around the loaded reference
  task automatic random_alignment();
    logic [MATE_W-1:0]     mate;
    logic [STRAND_W-1:0]   strand;
    logic [READ_LEN_W-1:0] len;
    int                    start;
    int                    off;
    int                    fill;
    fill = (loads_sent < REF_LEN) ? loads_sent : REF_LEN;
    mate = ($urandom_range(1)) ? MATE_1 : MATE_2;
    strand = (mate == MATE_1) ? STRAND_WW + STRAND_W'($urandom_range(1)) :
                                STRAND_WC + STRAND_W'($urandom_range(1));
    len = ($urandom_range(9) == 0) ? READ_LEN_W'($urandom_range(2047)) :
                                     READ_LEN_W'($urandom_range(24));
    start = $urandom_range(fill + 8);
    off = $urandom_range(start);
    send_record(OFFSET_W'(off), LOC_W'(start + 1 - off), len, mate, strand, 1'b1, 1'b1);
  endtask

  initial begin
    in_item_t it;
    int       pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    loads_sent = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty report, every character class, filter and clipping cases
    send_report();
    load_base(CH_A);
    load_base(CH_T);
    load_base(CH_G);
    load_base(CH_C);
    load_base(CH_N);
    load_base(8'h61);
    load_base(8'hFF);
    load_base(8'h00);
    load_base(CH_A);
    load_base(CH_C);
    send_record(0, 1, 2, MATE_1, STRAND_WW, 1'b1, 1'b1);
    send_record(2, 2, 1, MATE_2, STRAND_CC, 1'b1, 1'b1);
    send_record(0, 0, 3, MATE_2, STRAND_WC, 1'b1, 1'b1);
    send_record(7, 1, 2, MATE_1, STRAND_CW, 1'b1, 1'b1);
    send_record(0, 1, 10, MATE_BAD, STRAND_WW, 1'b1, 1'b1);
    send_record(0, 1, 10, MATE_OTHER, STRAND_WW, 1'b1, 1'b1);
    send_record(0, 1, 10, MATE_1, STRAND_WC, 1'b1, 1'b1);
    send_record(0, 1, 10, MATE_2, STRAND_CW, 1'b1, 1'b1);
    send_record(0, 1, 10, MATE_1, STRAND_WW, 1'b0, 1'b1);
    send_record(0, 1, 10, MATE_1, STRAND_WW, 1'b1, 1'b0);
    send_record('1, '1, '1, MATE_2, STRAND_WC, 1'b1, 1'b1);
    send_record(9, 1, 0, MATE_1, STRAND_WW, 1'b1, 1'b1);
    send_record(8, 1, 1100, MATE_1, STRAND_CW, 1'b1, 1'b1);
    it = random_item();
    it.cmd = CMD_UNUSED;
    send(it);
    send_report();

    // random mix, one stretch with no stalls on either side
    for (int n = 0; n < 500; n++) begin
      no_idle = (n >= 200 && n < 300);
      pick = $urandom_range(99);
      if (pick < 40) begin
        load_base(pick_base());
      end else if (pick < 80) begin
        random_alignment();
      end else if (pick < 90) begin
        it = random_item();
        it.cmd = CMD_RECORD;
        send(it);
      end else if (pick < 97) begin
        send_report();
      end else begin
        it = random_item();
        it.cmd = CMD_UNUSED;
        send(it);
      end
    end
    no_idle = 1'b0;

    // trailing loads, then records reaching past the loaded end
    load_base(CH_A);
    load_base(CH_G);
    send_record('1, 1, 8, MATE_1, STRAND_WW, 1'b1, 1'b1);
    send_record(65000, 40000, 100, MATE_2, STRAND_CC, 1'b1, 1'b1);
    send_record(100, 1, READ_LEN_W'(MAX_READ), MATE_2, STRAND_WC, 1'b1, 1'b1);
    send_report();
    in_valid = 1'b0;

    // drain, then let any trailing record finish
    while (pending != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
